/* src/audio_resample_mixer_assert.svh */
// assertion macros for the audio resample mixer
// used by audio_resample_mixer.sv, expects clk and arst_n in scope
`ifndef AUDIO_RESAMPLE_MIXER_ASSERT_SVH
`define AUDIO_RESAMPLE_MIXER_ASSERT_SVH

// checked only outside reset
`define ARM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ARM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/arm_pkg.sv */
// shared constants for the audio resample mixer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package arm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam int BEEPER_DEPTH_DEF = 4096;
	localparam int DSP_DEPTH_DEF    = 8192;

	// action codes
	localparam logic [1:0] ACT_PUSH_BEEPER = 2'd0;
	localparam logic [1:0] ACT_PUSH_DSP    = 2'd1;
	localparam logic [1:0] ACT_FRAME       = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BEEPER_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DC_CUTOFF     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 2'd2;

	// reset values
	localparam logic        BEEPER_ENABLE_RST = 1'b1;
	localparam logic [15:0] DC_CUTOFF_RST     = 16'd373;
	localparam logic [15:0] PHASE_STEP_RST    = 16'd11889;
	localparam logic signed [31:0] DC_TRACK_RST = -32'sd524288000; // -8000 in q16.16

endpackage

`default_nettype wire

/* src/arm_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module arm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/audio_resample_mixer.sv */
// audio resample mixer top level: beeper and dsp fifos, dc filter, interpolator, mixer
// depends on arm_pkg, arm_ram and audio_resample_mixer_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "audio_resample_mixer_assert.svh"

// channel   direction  handshake               payload
// input     in         in_valid / in_ready     action, sample
// output    out        out_valid / out_ready   mixed_sample, beeper_repeat, dsp_starved
// config    in         cfg_we                  cfg_index, cfg_data
//
// pushes may follow each other in every cycle while in_ready is high
// a frame goes accept -> s1 (fifo read data) -> s2 (mix) -> output register
// a frame occupies s1 until s2 has written back dc_track; a new frame enters as s1 empties
// out_valid rises when the frame leaves s2 for the output register
// async reset clears pointers and phase, presets dc_track; fifo contents stay undefined
// a stalled output backs up into s2 and s1, then in_ready drops

module audio_resample_mixer #(
	parameter int BEEPER_DEPTH = arm_pkg::BEEPER_DEPTH_DEF,
	parameter int DSP_DEPTH    = arm_pkg::DSP_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            cfg_we,
	input  wire logic [arm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [arm_pkg::CFG_W-1:0]       cfg_data,
	// input transactions
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [1:0]                      action,
	input  wire logic signed [arm_pkg::SAMPLE_W-1:0] sample,
	// output transactions
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [arm_pkg::SAMPLE_W-1:0]  mixed_sample,
	output logic                                 beeper_repeat,
	output logic                                 dsp_starved
);

	import arm_pkg::*;

	localparam int BAW = $clog2(BEEPER_DEPTH);
	localparam int DAW = $clog2(DSP_DEPTH);
	localparam int BCW = $clog2(BEEPER_DEPTH + 1);
	localparam int DCW = $clog2(DSP_DEPTH + 1);

	// configuration registers
	logic        beeper_enable_q;
	logic [15:0] dc_cutoff_q;
	logic [15:0] phase_step_q;

	// fifo pointers
	logic [BAW-1:0] brd_q, bwr_q;
	logic [BCW-1:0] bcnt_q;
	logic [DAW-1:0] drd_q, dwr_q;
	logic [DCW-1:0] dcnt_q;

	// filter and interpolator state
	logic signed [15:0] held_beep_q;
	logic signed [31:0] dc_track_q;
	logic [15:0]        phase_acc_q;
	logic signed [15:0] prev_dsp_q;
	logic signed [15:0] next_dsp_q;

	// pipeline control
	logic valid_s1, valid_s2, out_valid_q;
	logic adv1, adv2;

	// accept decode
	logic accept, is_bpush, is_dpush, is_frame;
	logic bfull, bempty, dfull, dempty;
	logic bwr_en, dwr_en, bpop, dpop, dstep;
	logic [16:0] phase_sum;

	// ram read data
	logic [15:0] bq, dq;

	// stage 1 payload
	logic        bpop_s1, brepeat_s1, dstep_s1, dpop_s1, ben_s1;
	logic [15:0] phase_s1;

	// stage 2 payload
	logic signed [32:0] p1_s2;
	logic signed [48:0] p2_s2;
	logic signed [15:0] x_s2, prv_s2, nxt_s2;
	logic [15:0]        phase_s2;
	logic               ben_s2, repeat_s2, starved_s2;

	// stage 1 logic
	logic signed [15:0] x_c, prv_c, nxt_c;
	logic signed [32:0] cut33;
	logic signed [48:0] cut49;

	// stage 2 logic
	logic signed [48:0] v_c, vsh_c, beep_full_c, np2_c;
	logic signed [18:0] beep_c;
	logic signed [34:0] tsum_c;
	logic signed [31:0] tnew_c;
	logic signed [16:0] diff_c, ph17_c;
	logic signed [34:0] prod_c, acc_c, accsh_c, dsp_full_c;
	logic signed [18:0] dsp_c;
	logic signed [19:0] mix_c;
	logic signed [15:0] mix_sat_c;

	// ---------------------------------------------------------------------
	// handshake and decode
	// ---------------------------------------------------------------------

	// s2 drains into the output register when it is free or being emptied
	assign adv2 = valid_s2 && (!out_valid_q || out_ready);
	// s1 waits for s2 to be empty so dc_track is already written back
	assign adv1 = valid_s1 && !valid_s2;

	assign in_ready = !valid_s1 || adv1;
	assign accept   = in_valid && in_ready;
	assign is_bpush = accept && (action == ACT_PUSH_BEEPER);
	assign is_dpush = accept && (action == ACT_PUSH_DSP);
	assign is_frame = accept && (action == ACT_FRAME);

	assign bfull  = (bcnt_q == BCW'(BEEPER_DEPTH));
	assign bempty = (bcnt_q == '0);
	assign dfull  = (dcnt_q == DCW'(DSP_DEPTH));
	assign dempty = (dcnt_q == '0);

	// a push into a full fifo is dropped
	assign bwr_en = is_bpush && !bfull;
	assign dwr_en = is_dpush && !dfull;

	// beeper pops only when enabled; dsp steps on a phase carry
	assign bpop      = is_frame && beeper_enable_q && !bempty;
	assign phase_sum = {1'b0, phase_acc_q} + {1'b0, phase_step_q};
	assign dstep     = is_frame && phase_sum[16];
	assign dpop      = dstep && !dempty;

	// ---------------------------------------------------------------------
	// fifo memories
	// ---------------------------------------------------------------------

	arm_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(BEEPER_DEPTH)
	) u_beeper_ram (
		.clk  (clk),
		.we   (bwr_en),
		.waddr(bwr_q),
		.wdata(sample),
		.re   (bpop),
		.raddr(brd_q),
		.rdata(bq)
	);

	arm_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DSP_DEPTH)
	) u_dsp_ram (
		.clk  (clk),
		.we   (dwr_en),
		.waddr(dwr_q),
		.wdata(sample),
		.re   (dpop),
		.raddr(drd_q),
		.rdata(dq)
	);

	// ---------------------------------------------------------------------
	// configuration and pointers
	// ---------------------------------------------------------------------

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beeper_enable_q <= BEEPER_ENABLE_RST;
			dc_cutoff_q     <= DC_CUTOFF_RST;
			phase_step_q    <= PHASE_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BEEPER_ENABLE: beeper_enable_q <= cfg_data[0];
				CFG_DC_CUTOFF:     dc_cutoff_q     <= cfg_data;
				CFG_PHASE_STEP:    phase_step_q    <= cfg_data;
				default: ; // index beyond the register list
			endcase
		end
	end

	// one transaction per cycle, so a fifo never sees push and pop together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brd_q  <= '0;
			bwr_q  <= '0;
			bcnt_q <= '0;
			drd_q  <= '0;
			dwr_q  <= '0;
			dcnt_q <= '0;
		end else begin
			if (bwr_en) begin
				bwr_q  <= (bwr_q == BAW'(BEEPER_DEPTH - 1)) ? '0 : bwr_q + 1'b1;
				bcnt_q <= bcnt_q + 1'b1;
			end else if (bpop) begin
				brd_q  <= (brd_q == BAW'(BEEPER_DEPTH - 1)) ? '0 : brd_q + 1'b1;
				bcnt_q <= bcnt_q - 1'b1;
			end
			if (dwr_en) begin
				dwr_q  <= (dwr_q == DAW'(DSP_DEPTH - 1)) ? '0 : dwr_q + 1'b1;
				dcnt_q <= dcnt_q + 1'b1;
			end else if (dpop) begin
				drd_q  <= (drd_q == DAW'(DSP_DEPTH - 1)) ? '0 : drd_q + 1'b1;
				dcnt_q <= dcnt_q - 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// accept stage: phase advance and s1 capture
	// ---------------------------------------------------------------------

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (is_frame) begin
				phase_acc_q <= phase_sum[15:0];
			end
			if (is_frame) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_frame) begin
			bpop_s1    <= bpop;
			brepeat_s1 <= beeper_enable_q && !bpop;
			ben_s1     <= beeper_enable_q;
			dstep_s1   <= dstep;
			dpop_s1    <= dpop;
			phase_s1   <= phase_sum[15:0];
		end
	end

	// ---------------------------------------------------------------------
	// s1: ram data in hand, filter products and dsp window update
	// ---------------------------------------------------------------------

	always_comb begin
		x_c   = bpop_s1 ? signed'(bq) : held_beep_q;
		prv_c = dstep_s1 ? next_dsp_q : prev_dsp_q;
		if (dstep_s1) begin
			nxt_c = dpop_s1 ? signed'(dq) : '0;
		end else begin
			nxt_c = next_dsp_q;
		end
		cut33 = 33'(signed'({1'b0, dc_cutoff_q}));
		cut49 = 49'(signed'({1'b0, dc_cutoff_q}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_beep_q <= '0;
			prev_dsp_q  <= '0;
			next_dsp_q  <= '0;
			valid_s2    <= 1'b0;
		end else begin
			if (adv1) begin
				if (bpop_s1) begin
					held_beep_q <= x_c;
				end
				prev_dsp_q <= prv_c;
				next_dsp_q <= nxt_c;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
			end else if (adv2) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// c*v is split as (c*x)<<16 - c*track to keep each product narrow
	always_ff @(posedge clk) begin
		if (adv1) begin
			p1_s2      <= cut33 * 33'(x_c);
			p2_s2      <= cut49 * 49'(dc_track_q);
			x_s2       <= x_c;
			ben_s2     <= ben_s1;
			repeat_s2  <= brepeat_s1;
			starved_s2 <= dstep_s1 && !dpop_s1;
			prv_s2     <= prv_c;
			nxt_s2     <= nxt_c;
			phase_s2   <= phase_s1;
		end
	end

	// ---------------------------------------------------------------------
	// s2: filter output, track update, interpolation and mix
	// ---------------------------------------------------------------------

	always_comb begin
		// beeper term: (x*65536 - track) / 65536 towards zero
		v_c         = (49'(x_s2) <<< 16) - 49'(dc_track_q);
		vsh_c       = v_c >>> 16;
		beep_full_c = vsh_c + 49'(v_c[48] && (v_c[15:0] != '0));
		beep_c      = ben_s2 ? 19'(beep_full_c) : '0;

		// new track: track + p1 + floor(-p2 / 65536), saturated
		np2_c  = -p2_s2;
		tsum_c = 35'(dc_track_q) + 35'(p1_s2) + 35'(np2_c >>> 16);
		if (tsum_c > 35'sd2147483647) begin
			tnew_c = 32'sh7fffffff;
		end else if (tsum_c < -35'sd2147483648) begin
			tnew_c = 32'sh80000000;
		end else begin
			tnew_c = 32'(tsum_c);
		end

		// dsp term: prev + (next - prev) * phase, q0.16 towards zero
		diff_c     = 17'(nxt_s2) - 17'(prv_s2);
		ph17_c     = signed'({1'b0, phase_s2});
		prod_c     = 35'(diff_c) * 35'(ph17_c);
		acc_c      = (35'(prv_s2) <<< 16) + prod_c;
		accsh_c    = acc_c >>> 16;
		dsp_full_c = accsh_c + 35'(acc_c[34] && (acc_c[15:0] != '0));
		dsp_c      = 19'(dsp_full_c);

		// mix and saturate to 16 bits
		mix_c = 20'(beep_c) + 20'(dsp_c);
		if (mix_c > 20'sd32767) begin
			mix_sat_c = 16'sh7fff;
		end else if (mix_c < -20'sd32768) begin
			mix_sat_c = 16'sh8000;
		end else begin
			mix_sat_c = 16'(mix_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_track_q  <= DC_TRACK_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (adv2 && ben_s2) begin
				dc_track_q <= tnew_c;
			end
			if (adv2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv2) begin
			mixed_sample  <= mix_sat_c;
			beeper_repeat <= repeat_s2;
			dsp_starved   <= starved_s2;
		end
	end

	assign out_valid = out_valid_q;

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------

	`ARM_ASSERT_ALWAYS(a_rst_out, !arst_n |=> !out_valid_q, "output valid after reset")
	`ARM_ASSERT(a_bcnt_range, bcnt_q <= BCW'(BEEPER_DEPTH), "beeper fill count beyond depth")
	`ARM_ASSERT(a_dcnt_range, dcnt_q <= DCW'(DSP_DEPTH), "dsp fill count beyond depth")
	`ARM_ASSERT(a_interlock, (valid_s1 && valid_s2) |-> !in_ready, "frame taken while track busy")
	`ARM_ASSERT(a_s2_hold, (valid_s2 && out_valid_q && !out_ready) |=> valid_s2, "result lost in s2")

endmodule

`default_nettype wire
